// File: rtl/bfgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfgl_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_WRITE_GLYPH = 2'd0;
    localparam logic [1:0] OP_START       = 2'd1;
    localparam logic [1:0] OP_PLACE       = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_J       = 8'd106;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Gap added below a line and to the width bound.
    localparam logic signed [17:0] LINE_GAP = 18'sd2;

    localparam logic signed [17:0] SAT16_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT16_MIN = -18'sd32768;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         char_code;
        logic [11:0]        glyph_src_x;
        logic [11:0]        glyph_src_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  glyph_x_offset;
        logic signed [7:0]  glyph_y_offset;
        logic [7:0]         glyph_advance;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } bfgl_in_t;

    typedef struct packed {
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [14:0]        bounds_width;
        logic [14:0]        bounds_height;
    } bfgl_out_t;

    // One glyph table entry, 64 bits.
    typedef struct packed {
        logic [11:0]       sx;
        logic [11:0]       sy;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] xo;
        logic signed [7:0] yo;
        logic [7:0]        adv;
    } glyph_t;

    localparam int GLYPH_BITS = $bits(glyph_t);

    // Clamp an 18-bit signed sum to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > SAT16_MAX) begin
            r = 16'sh7FFF;
        end else if (v < SAT16_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp an 18-bit signed sum to 0..32767.
    function automatic logic [14:0] sat15u(input logic signed [17:0] v);
        logic [14:0] r;
        if (v < 18'sd0) begin
            r = 15'd0;
        end else if (v > SAT16_MAX) begin
            r = 15'h7FFF;
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bfgl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfgl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bitmap_font_glyph_layout.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload     Handshake
// s_        in         bfgl_in_t   s_valid / s_ready, transfer on both high
// m_        out        bfgl_out_t  m_valid / m_ready, transfer on both high
//
// A glyph write, a string start, a space, a tab or a newline is done in idle.
// An ordinary character first reads its entry from the glyph RAM, whose read
// port is registered, and then forms the result in the lookup state.
// A synchronous active-low reset clears the cursor, origin, bounds and the
// per-entry valid bits, so every glyph reads as zero until it is written.
// A result waiting in the output register does not block glyph writes, starts
// or cursor moves; only the next ordinary character waits for it to leave.

module bitmap_font_glyph_layout
    import bfgl_pkg::*;
#(
    parameter int GLYPH_ENTRIES = 256
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire bfgl_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bfgl_out_t      m_data
);

    localparam int ADDR_BITS = $clog2(GLYPH_ENTRIES);
    localparam logic [8:0] ENTRY_LIMIT = 9'(GLYPH_ENTRIES);

    // Idle takes new transfers; lookup waits for the RAM data and for room in
    // the output register.
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic                     state_reg, state_next;
    logic signed [15:0]       cursor_x_reg, cursor_x_next;
    logic signed [15:0]       cursor_y_reg, cursor_y_next;
    logic signed [15:0]       start_x_reg, start_x_next;
    logic signed [15:0]       start_y_reg, start_y_next;
    logic [14:0]              extent_w_reg, extent_w_next;
    logic [14:0]              extent_h_reg, extent_h_next;
    logic [GLYPH_ENTRIES-1:0] valid_reg, valid_next;
    glyph_t                   glyph_j_reg, glyph_j_next;
    logic                     hit_reg, hit_next;
    logic                     m_valid_reg, m_valid_next;
    bfgl_out_t                m_data_reg, m_data_next;

    logic                     accept;
    logic                     in_range;
    logic [ADDR_BITS-1:0]     addr;
    glyph_t                   wr_glyph;
    logic                     ram_we;
    logic                     ram_re;
    logic [GLYPH_BITS-1:0]    ram_rdata;
    glyph_t                   g;

    logic signed [17:0] cx18, cy18, sx18, sy18;
    logic signed [17:0] j_adv18, j_w18, j_h18;
    logic signed [17:0] dx18, dy18;
    logic signed [17:0] space_sum, tab_sum, nl_sum;
    logic signed [17:0] ext_w_sum, ext_h_sum;
    logic signed [17:0] dest_x_sum, dest_y_sum, adv_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_range = ({1'b0, s_data.char_code} < ENTRY_LIMIT);
    assign addr     = s_data.char_code[ADDR_BITS-1:0];

    assign wr_glyph = '{
        sx:  s_data.glyph_src_x,
        sy:  s_data.glyph_src_y,
        w:   s_data.glyph_width,
        h:   s_data.glyph_height,
        xo:  s_data.glyph_x_offset,
        yo:  s_data.glyph_y_offset,
        adv: s_data.glyph_advance
    };

    assign ram_we = accept && (s_data.opcode == OP_WRITE_GLYPH) && in_range;
    assign ram_re = accept && (s_data.opcode == OP_PLACE);

    bfgl_ram #(
        .WIDTH (GLYPH_BITS),
        .DEPTH (GLYPH_ENTRIES)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr),
        .wr_data (wr_glyph),
        .rd_en   (ram_re),
        .rd_addr (addr),
        .rd_data (ram_rdata)
    );

    // An entry never written since reset reads as an all-zero glyph, as does
    // a code beyond the table.
    assign g = hit_reg ? glyph_t'(ram_rdata) : '0;

    // Everything is worked out in 18 bits, which holds any sum below without
    // overflow, and then clamped.
    always_comb begin
        cx18    = {{2{cursor_x_reg[15]}}, cursor_x_reg};
        cy18    = {{2{cursor_y_reg[15]}}, cursor_y_reg};
        sx18    = {{2{start_x_reg[15]}}, start_x_reg};
        sy18    = {{2{start_y_reg[15]}}, start_y_reg};
        j_adv18 = $signed({10'd0, glyph_j_reg.adv});
        j_w18   = $signed({10'd0, glyph_j_reg.w});
        j_h18   = $signed({10'd0, glyph_j_reg.h});

        space_sum = cx18 + j_adv18;
        tab_sum   = cx18 + $signed({8'd0, glyph_j_reg.adv, 2'b00});
        nl_sum    = cy18 + j_h18 + LINE_GAP;

        dx18      = cx18 - sx18;
        dy18      = cy18 - sy18;
        ext_w_sum = dx18 + j_w18 + j_adv18 + LINE_GAP;
        ext_h_sum = dy18 + j_h18 + LINE_GAP;

        dest_x_sum = cx18 + {{10{g.xo[7]}}, g.xo};
        dest_y_sum = cy18 + {{10{g.yo[7]}}, g.yo};
        adv_sum    = cx18 + $signed({10'd0, g.adv});
    end

    always_comb begin
        state_next    = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        extent_w_next = extent_w_reg;
        extent_h_next = extent_h_reg;
        valid_next    = valid_reg;
        glyph_j_next  = glyph_j_reg;
        hit_next      = hit_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.opcode)
                        OP_WRITE_GLYPH: begin
                            if (in_range) begin
                                valid_next[addr] = 1'b1;
                            end
                            // Glyph 'j' sets the spacing, so a copy of it is
                            // kept beside the RAM.
                            if (s_data.char_code == CHAR_J) begin
                                glyph_j_next = wr_glyph;
                            end
                        end
                        OP_START: begin
                            cursor_x_next = s_data.origin_x;
                            cursor_y_next = s_data.origin_y;
                            start_x_next  = s_data.origin_x;
                            start_y_next  = s_data.origin_y;
                            extent_w_next = '0;
                            extent_h_next = '0;
                        end
                        OP_PLACE: begin
                            if (s_data.char_code == CHAR_SPACE) begin
                                cursor_x_next = sat16(space_sum);
                            end else if (s_data.char_code == CHAR_TAB) begin
                                cursor_x_next = sat16(tab_sum);
                            end else if (s_data.char_code == CHAR_NEWLINE) begin
                                cursor_x_next = start_x_reg;
                                cursor_y_next = sat16(nl_sum);
                            end else begin
                                hit_next   = in_range && valid_reg[addr];
                                state_next = ST_LOOKUP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // The cursor has not moved since the read was issued, as no
                // transfer is taken in this state.
                if (!m_valid_reg || m_ready) begin
                    if (dx18 > $signed({3'd0, extent_w_reg})) begin
                        extent_w_next = sat15u(ext_w_sum);
                    end
                    extent_h_next = sat15u(ext_h_sum);

                    m_data_next.src_x         = g.sx;
                    m_data_next.src_y         = g.sy;
                    m_data_next.rect_width    = g.w;
                    m_data_next.rect_height   = g.h;
                    m_data_next.dest_x        = sat16(dest_x_sum);
                    m_data_next.dest_y        = sat16(dest_y_sum);
                    m_data_next.bounds_width  = extent_w_next;
                    m_data_next.bounds_height = extent_h_next;
                    m_valid_next              = 1'b1;

                    cursor_x_next = sat16(adv_sum);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            extent_w_reg <= '0;
            extent_h_reg <= '0;
            valid_reg    <= '0;
            glyph_j_reg  <= '0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            start_x_reg  <= start_x_next;
            start_y_reg  <= start_y_next;
            extent_w_reg <= extent_w_next;
            extent_h_reg <= extent_h_next;
            valid_reg    <= valid_next;
            glyph_j_reg  <= glyph_j_next;
            hit_reg      <= hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // An ordinary character always goes on to the lookup state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.opcode == OP_PLACE) && (s_data.char_code != CHAR_SPACE)
            && (s_data.char_code != CHAR_TAB) && (s_data.char_code != CHAR_NEWLINE))
        |=> (state_reg == ST_LOOKUP))
        else $error("ordinary character did not start a lookup");

    // A new result only appears when a lookup completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result raised outside a lookup");

    // The cursor does not move while a lookup is waiting for the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) && m_valid_reg && !m_ready
        |=> $stable(cursor_x_reg) && $stable(cursor_y_reg))
        else $error("cursor moved during a stalled lookup");

    // A write to glyph 'j' updates the spacing copy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.opcode == OP_WRITE_GLYPH) && (s_data.char_code == CHAR_J)
        |=> (glyph_j_reg.adv == $past(s_data.glyph_advance))
            && (glyph_j_reg.h == $past(s_data.glyph_height)))
        else $error("glyph j copy not updated");

endmodule

`default_nettype wire

// File: tb/bitmap_font_glyph_layout_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the glyph layout block. Every transfer that the block accepts
// on the input channel is run through a behavioural layout engine kept here, which holds its
// own glyph metrics, cursor, string origin and running bounds. Glyph placements that the
// engine predicts are queued in order, and every transfer on the result channel is compared
// field by field with the oldest queued placement.
module bitmap_font_glyph_layout_tb
    import bfgl_pkg::*;
();

    localparam int FONT_ENTRIES = 256;
    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int REPORT_LIMIT = 10;

    // Layout constants: a tab is four spaces, and a new line drops by the height of 'j'
    // plus a fixed gap, which is also added to the width bound.
    localparam int TAB_STOPS    = 4;
    localparam int LINE_SPACING = 2;

    // Opcode 3 has no meaning and must be ignored by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Codes that are placed as ordinary glyphs although they look like control codes.
    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // Every input of the block holds a known value from time zero onwards.
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    bfgl_in_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    bfgl_out_t m_data;

    bitmap_font_glyph_layout #(
        .GLYPH_ENTRIES(FONT_ENTRIES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // State of the behavioural layout engine, mirroring the block after reset.
    glyph_t    font_metrics [0:FONT_ENTRIES-1];
    int        cursor_x;
    int        cursor_y;
    int        start_x;
    int        start_y;
    int        extent_w;
    int        extent_h;

    // Placements still owed by the block, oldest first.
    bfgl_out_t placed_glyphs_q [$];

    // Run statistics and failure bookkeeping.
    int        cycle_count    = 0;
    int        error_count    = 0;
    int        glyphs_checked = 0;
    int        glyph_writes   = 0;
    int        string_starts  = 0;
    int        cursor_moves   = 0;
    int        ignored_items  = 0;
    int        dest_clamps    = 0;

    // Idling controls: the test tasks switch these off to get stretches at full rate.
    bit        tx_idling     = 1'b1;
    bit        rx_idling     = 1'b1;
    int        rx_stall_left = 0;
    int        rx_gap;

    initial begin
        for (int i = 0; i < FONT_ENTRIES; i++) begin
            font_metrics[i] = '0;
        end
        cursor_x = 0;
        cursor_y = 0;
        start_x  = 0;
        start_y  = 0;
        extent_w = 0;
        extent_h = 0;
    end

    // Clamp to the signed 16-bit coordinate range.
    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Clamp to the 15-bit unsigned bounds range.
    function automatic int clamp15(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < 0) begin
            return 0;
        end
        return v;
    endfunction

    // Advances the layout engine by one accepted transfer. Returns 1 when the transfer places
    // a glyph, with the placement the block must produce in glyph_out.
    function automatic bit predict_placement(input bfgl_in_t item, output bfgl_out_t glyph_out);
        glyph_t j_metrics;
        glyph_t g;
        int     dx;
        int     dy;
        glyph_out = '0;
        case (item.opcode)
            OP_WRITE_GLYPH: begin
                // Writes past the end of a smaller table are dropped.
                if (int'(item.char_code) < FONT_ENTRIES) begin
                    g.sx  = item.glyph_src_x;
                    g.sy  = item.glyph_src_y;
                    g.w   = item.glyph_width;
                    g.h   = item.glyph_height;
                    g.xo  = item.glyph_x_offset;
                    g.yo  = item.glyph_y_offset;
                    g.adv = item.glyph_advance;
                    font_metrics[item.char_code] = g;
                end
                glyph_writes++;
                return 1'b0;
            end
            OP_START: begin
                start_x  = int'(item.origin_x);
                start_y  = int'(item.origin_y);
                cursor_x = start_x;
                cursor_y = start_y;
                extent_w = 0;
                extent_h = 0;
                string_starts++;
                return 1'b0;
            end
            OP_PLACE: begin
            end
            default: begin
                ignored_items++;
                return 1'b0;
            end
        endcase

        // Space, tab and new line only move the cursor, all measured on glyph 'j'.
        j_metrics = font_metrics[CHAR_J];
        if (item.char_code == CHAR_SPACE) begin
            cursor_x = clamp16(cursor_x + int'(j_metrics.adv));
            cursor_moves++;
            return 1'b0;
        end
        if (item.char_code == CHAR_TAB) begin
            cursor_x = clamp16(cursor_x + int'(j_metrics.adv) * TAB_STOPS);
            cursor_moves++;
            return 1'b0;
        end
        if (item.char_code == CHAR_NEWLINE) begin
            cursor_x = start_x;
            cursor_y = clamp16(cursor_y + int'(j_metrics.h) + LINE_SPACING);
            cursor_moves++;
            return 1'b0;
        end

        // The width bound only grows once the cursor is strictly right of the origin.
        if (cursor_x - start_x > extent_w) begin
            extent_w = clamp15(cursor_x - start_x + int'(j_metrics.w) + int'(j_metrics.adv)
                               + LINE_SPACING);
        end
        extent_h = clamp15(cursor_y - start_y + int'(j_metrics.h) + LINE_SPACING);

        g = (int'(item.char_code) < FONT_ENTRIES) ? font_metrics[item.char_code] : glyph_t'('0);
        dx = cursor_x + int'(g.xo);
        dy = cursor_y + int'(g.yo);
        if (dx > 32767 || dx < -32768 || dy > 32767 || dy < -32768) begin
            dest_clamps++;
        end
        glyph_out.src_x         = g.sx;
        glyph_out.src_y         = g.sy;
        glyph_out.rect_width    = g.w;
        glyph_out.rect_height   = g.h;
        glyph_out.dest_x        = clamp16(dx);
        glyph_out.dest_y        = clamp16(dy);
        glyph_out.bounds_width  = extent_w[14:0];
        glyph_out.bounds_height = extent_h[14:0];
        cursor_x = clamp16(cursor_x + int'(g.adv));
        return 1'b1;
    endfunction

    // Length of an idle stretch: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // A random field value that hits all zeros, all ones and the sign boundaries often.
    function automatic logic [15:0] pick_bits(input int width);
        logic [15:0] mask;
        logic [15:0] msb;
        int          r;
        mask = 16'((32'd1 << width) - 1);
        msb  = 16'(32'd1 << (width - 1));
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return mask;
            2:       return msb;
            3:       return mask & ~msb;
            default: return 16'($urandom()) & mask;
        endcase
    endfunction

    // A transfer with every field random, so that fields the opcode does not use still move.
    function automatic bfgl_in_t random_item();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(bfgl_in_t)-1:0];
    endfunction

    function automatic bfgl_in_t glyph_write_item(input logic [7:0] code,
                                                  input logic [11:0] sx,
                                                  input logic [11:0] sy,
                                                  input logic [7:0] w,
                                                  input logic [7:0] h,
                                                  input logic signed [7:0] xo,
                                                  input logic signed [7:0] yo,
                                                  input logic [7:0] adv);
        bfgl_in_t item;
        item = random_item();
        item.opcode         = OP_WRITE_GLYPH;
        item.char_code      = code;
        item.glyph_src_x    = sx;
        item.glyph_src_y    = sy;
        item.glyph_width    = w;
        item.glyph_height   = h;
        item.glyph_x_offset = xo;
        item.glyph_y_offset = yo;
        item.glyph_advance  = adv;
        return item;
    endfunction

    function automatic bfgl_in_t start_item(input logic signed [15:0] x,
                                            input logic signed [15:0] y);
        bfgl_in_t item;
        item = random_item();
        item.opcode   = OP_START;
        item.origin_x = x;
        item.origin_y = y;
        return item;
    endfunction

    function automatic bfgl_in_t place_item(input logic [7:0] code);
        bfgl_in_t item;
        item = random_item();
        item.opcode    = OP_PLACE;
        item.char_code = code;
        return item;
    endfunction

    function automatic bfgl_in_t random_glyph_write(input logic [7:0] code);
        return glyph_write_item(code, 12'(pick_bits(12)), 12'(pick_bits(12)),
                                8'(pick_bits(8)), 8'(pick_bits(8)),
                                8'(pick_bits(8)), 8'(pick_bits(8)), 8'(pick_bits(8)));
    endfunction

    // Character of running text: mostly printable, with the cursor-moving codes mixed in.
    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) begin
            return CHAR_SPACE;
        end
        if (r < 19) begin
            return CHAR_TAB;
        end
        if (r < 26) begin
            return CHAR_NEWLINE;
        end
        if (r < 31) begin
            return CHAR_J;
        end
        if (r < 34) begin
            return ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_NUL;
        end
        if (r < 85) begin
            return 8'($urandom_range(33, 126));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // String origins: mostly near the middle of the plane, some anywhere, some at the edges.
    function automatic logic signed [15:0] pick_origin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 16'($urandom_range(0, 4000) - 2000);
        end
        if (r < 85) begin
            return pick_bits(16);
        end
        if ($urandom_range(0, 1) != 0) begin
            return 16'($urandom_range(32767 - 3000, 32767));
        end
        return 16'($urandom_range(0, 3000) - 32768);
    endfunction

    // Offers one transfer and returns once the block has taken it. Valid is left high so
    // that a following transfer can go out back to back; anything that waits for other
    // reasons lowers it first.
    task automatic send_item(input bfgl_in_t item);
        bfgl_out_t placement;
        int        gap;
        gap = tx_idling ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // A result is registered only in the lookup state after the transfer, so the queue is filled in time.
        if (predict_placement(item, placement)) begin
            placed_glyphs_q.push_back(placement);
        end
    endtask

    // Holds the sender off until every predicted placement has been seen or the drain limit runs out.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (placed_glyphs_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Extremes of every glyph field, saturation in both directions, the codes that look like
    // control codes, the unused opcode and placement before any string start.
    task automatic test_directed_cases();
        // Nothing written and no start yet: a zero glyph at the reset origin.
        send_item(place_item(8'h41));
        send_item(glyph_write_item(CHAR_J, 12'hFFF, 12'h000, 8'hFF, 8'hFF,
                                   -8'sd128, 8'sd127, 8'hFF));
        send_item(glyph_write_item(CHAR_NUL, 12'h000, 12'hFFF, 8'h00, 8'hFF,
                                   8'sd127, -8'sd128, 8'h00));
        send_item(glyph_write_item(CHAR_CR, 12'h001, 12'h002, 8'h08, 8'h0A,
                                   8'sd0, 8'sd0, 8'h08));
        send_item(glyph_write_item(8'hFF, 12'hFFF, 12'hFFF, 8'hFF, 8'h00,
                                   8'sd127, 8'sd127, 8'hFF));
        // Near the right edge: the first glyph leaves the width bound at zero, then the
        // space and tab push the cursor into saturation.
        send_item(start_item(16'sd32000, -16'sd32768));
        send_item(place_item(CHAR_J));
        send_item(place_item(CHAR_SPACE));
        send_item(place_item(CHAR_TAB));
        send_item(place_item(CHAR_NUL));
        send_item(place_item(CHAR_CR));
        send_item(place_item(8'hFF));
        send_item(start_item(16'sd5, 16'sd5) ^ {OP_UNUSED ^ OP_START, 104'd0});
        send_item(place_item(CHAR_NEWLINE));
        send_item(place_item(CHAR_J));
        // Bottom-left corner: destinations clamp low in x and the new line clamps in y.
        send_item(start_item(-16'sd32768, 16'sd32767));
        send_item(place_item(CHAR_NUL));
        send_item(place_item(CHAR_J));
        send_item(place_item(CHAR_NEWLINE));
        send_item(place_item(8'hFF));
        // A 'j' with no advance: space and tab leave the cursor where it is.
        send_item(start_item(16'sd0, 16'sd0));
        send_item(glyph_write_item(CHAR_J, 12'h000, 12'h000, 8'h00, 8'h00,
                                   8'sd0, 8'sd0, 8'h00));
        send_item(place_item(CHAR_SPACE));
        send_item(place_item(CHAR_TAB));
        send_item(place_item(CHAR_J));
    endtask

    // The sender stops dead until the block has emptied, then resumes at full rate.
    task automatic test_drain_and_resume();
        tx_idling = 1'b0;
        send_item(glyph_write_item(CHAR_J, 12'd40, 12'd80, 8'd7, 8'd12, 8'sd0, -8'sd10, 8'd8));
        send_item(start_item(16'sd100, 16'sd200));
        for (int i = 0; i < 12; i++) begin
            send_item(place_item(pick_text_char()));
        end
        wait_for_drain();
        for (int i = 0; i < 12; i++) begin
            send_item(place_item(pick_text_char()));
        end
        tx_idling = 1'b1;
    endtask

    // Mostly well-formed text: font updates, string starts and runs of characters. The rest
    // is fully random transfers, the unused opcode among them, and the odd full drain.
    task automatic test_random_text();
        int sent;
        int r;
        int run;
        sent = 0;
        // Populate 'j' and a spread of printable glyphs so that most placements are non-zero.
        send_item(random_glyph_write(CHAR_J));
        for (int i = 0; i < 40; i++) begin
            send_item(random_glyph_write(8'($urandom_range(33, 126))));
        end
        while (sent < RANDOM_ITEMS) begin
            tx_idling = ($urandom_range(0, 4) != 0);
            rx_idling = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                run = $urandom_range(1, 6);
                for (int i = 0; i < run; i++) begin
                    send_item(random_glyph_write(($urandom_range(0, 9) < 4) ? CHAR_J
                                                 : 8'($urandom_range(0, 255))));
                end
            end else if (r < 82) begin
                run = $urandom_range(1, 40);
                send_item(start_item(pick_origin(), pick_origin()));
                for (int i = 0; i < run; i++) begin
                    if ($urandom_range(0, 99) < 3) begin
                        send_item(place_item(8'h00) ^ {OP_UNUSED ^ OP_PLACE, 104'd0});
                    end else begin
                        send_item(place_item(pick_text_char()));
                    end
                end
            end else if (r < 95) begin
                run = $urandom_range(1, 4);
                for (int i = 0; i < run; i++) begin
                    send_item(random_item());
                end
            end else begin
                wait_for_drain();
                run = 0;
            end
            sent += run;
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // The receiver stalls at random, in short and occasional long stretches.
    always @(posedge aclk) begin
        if (rx_stall_left != 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            rx_gap = rx_idling ? idle_length() : 0;
            if (rx_gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready       <= 1'b0;
                rx_stall_left <= rx_gap - 1;
            end
        end
    end

    // Every result transfer is matched against the oldest predicted placement.
    always @(posedge aclk) begin
        bfgl_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (placed_glyphs_q.size() == 0) begin
                if (error_count < REPORT_LIMIT) begin
                    $display("[%0t] unexpected glyph result %h with nothing outstanding",
                             $realtime, m_data);
                end
                error_count++;
            end else begin
                want = placed_glyphs_q.pop_front();
                glyphs_checked++;
                if (m_data.src_x !== want.src_x || m_data.src_y !== want.src_y
                        || m_data.rect_width !== want.rect_width
                        || m_data.rect_height !== want.rect_height
                        || m_data.dest_x !== want.dest_x || m_data.dest_y !== want.dest_y
                        || m_data.bounds_width !== want.bounds_width
                        || m_data.bounds_height !== want.bounds_height) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("[%0t] glyph %0d mismatch: expected src=(%0d,%0d) size=%0dx%0d",
                                 $realtime, glyphs_checked, want.src_x, want.src_y,
                                 want.rect_width, want.rect_height);
                        $display("    dest=(%0d,%0d) bounds=%0dx%0d", want.dest_x, want.dest_y,
                                 want.bounds_width, want.bounds_height);
                        $display("    actual src=(%0d,%0d) size=%0dx%0d dest=(%0d,%0d) bounds=%0dx%0d",
                                 m_data.src_x, m_data.src_y, m_data.rect_width,
                                 m_data.rect_height, m_data.dest_x, m_data.dest_y,
                                 m_data.bounds_width, m_data.bounds_height);
                    end
                    error_count++;
                end
            end
        end
    end

    // A hung handshake ends the run rather than letting it spin forever.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // Reset is held at the start and then released for good.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_drain_and_resume();
        test_random_text();

        // Wait for the last placements, then let the block settle to catch anything stray.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (placed_glyphs_q.size() != 0) begin
            $display("%0d predicted glyph results never arrived", placed_glyphs_q.size());
            error_count += placed_glyphs_q.size();
        end

        $display("Checked %0d glyph placements (%0d with clamped destinations) in %0d cycles.",
                 glyphs_checked, dest_clamps, cycle_count);
        $display("Also sent %0d glyph writes, %0d string starts, %0d cursor moves, %0d ignored.",
                 glyph_writes, string_starts, cursor_moves, ignored_items);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
